/* src/expiring_keyed_cache_round_robin_unit_macros.svh */
`ifndef EXPIRING_KEYED_CACHE_ROUND_ROBIN_UNIT_MACROS_SVH
`define EXPIRING_KEYED_CACHE_ROUND_ROBIN_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EKC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ekc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ekc: next-cycle check failed");

`endif

/* src/ekc_pkg.sv */
package ekc_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned ENTRY_W       = 4 * KEY_W;
  localparam int unsigned SLOT_OUT_W    = 6;
  localparam int unsigned LIFE_W        = 16;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd20;

  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_FILLED = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ekc_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ekc_sts_t;

endpackage

/* src/ekc_ctrl.sv */
module ekc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ekc_pkg::ekc_sts_t sts_i,
  output ekc_pkg::ekc_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/ekc_datapath.sv */
module ekc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ekc_pkg::LIFE_W-1:0]    cfg_data_i,
  input  logic [31:0]                   host_address_i,
  input  logic [31:0]                   program_number_i,
  input  logic [31:0]                   program_version_i,
  input  logic [31:0]                   now_seconds_i,
  input  logic                          create_ok_i,
  input  ekc_pkg::ekc_cmd_t             cmd_i,
  output ekc_pkg::ekc_sts_t             sts_o,
  output logic [1:0]                    status_o,
  output logic [ekc_pkg::SLOT_OUT_W-1:0] slot_index_o,
  output logic                          evicted_o,
  output logic [31:0]                   forced_total_o
);

  logic [ekc_pkg::ENTRY_W-1:0] entry_mem [ekc_pkg::TABLE_ENTRIES];
  logic [ekc_pkg::TABLE_ENTRIES-1:0] valid_q;

  logic [ekc_pkg::LIFE_W-1:0] lifetime_q;
  logic [31:0] addr_q, prog_q, vers_q, now_q;
  logic        ok_q;

  logic [ekc_pkg::CNT_W-1:0]   issue_q;
  logic                        cmp_en_q;
  logic [ekc_pkg::IDX_W-1:0]   cmp_idx_q;
  logic [ekc_pkg::ENTRY_W-1:0] rd_q;
  logic                        found_q;
  logic [ekc_pkg::IDX_W-1:0]   hit_slot_q;
  logic [31:0]                 exp_q;

  logic [ekc_pkg::CNT_W-1:0] ptr_q;
  logic [31:0]               forced_q;

  logic [1:0]                    status_q;
  logic [ekc_pkg::SLOT_OUT_W-1:0] slot_out_q;
  logic                          evicted_q;

  logic                          issue_full;
  logic                          hit_now;
  logic                          live;
  logic [ekc_pkg::CNT_W-1:0]     ptr_wrap;
  logic [ekc_pkg::IDX_W-1:0]     chosen;
  logic                          victim;
  logic [31:0]                   fill_exp;
  logic [ekc_pkg::SLOT_OUT_W+ekc_pkg::IDX_W-1:0] chosen_ext;

  assign issue_full = (issue_q == ekc_pkg::CNT_W'(ekc_pkg::TABLE_ENTRIES));
  assign hit_now    = cmp_en_q && valid_q[cmp_idx_q] &&
                      (rd_q[127:96] == addr_q) && (rd_q[95:64] == prog_q) &&
                      (rd_q[63:32] == vers_q);
  assign sts_o.scan_done = hit_now || (!cmp_en_q && issue_full);

  assign live     = found_q && !(exp_q < now_q);
  assign ptr_wrap = (ptr_q >= ekc_pkg::CNT_W'(ekc_pkg::TABLE_ENTRIES)) ? '0 : ptr_q;
  assign chosen   = found_q ? hit_slot_q : ptr_wrap[ekc_pkg::IDX_W-1:0];
  assign victim   = valid_q[chosen];
  assign fill_exp = now_q + {{(32-ekc_pkg::LIFE_W){1'b0}}, lifetime_q};
  assign chosen_ext = {{ekc_pkg::SLOT_OUT_W{1'b0}}, chosen};

  // Table storage: one read port for the scan, one write port for refill.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && !issue_full) begin
      rd_q <= entry_mem[issue_q[ekc_pkg::IDX_W-1:0]];
    end
    if (cmd_i.commit && !live && ok_q) begin
      entry_mem[chosen] <= {addr_q, prog_q, vers_q, fill_exp};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= host_address_i;
      prog_q <= program_number_i;
      vers_q <= program_version_i;
      now_q  <= now_seconds_i;
      ok_q   <= create_ok_i;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= issue_q[ekc_pkg::IDX_W-1:0];
      if (hit_now && !found_q) begin
        hit_slot_q <= cmp_idx_q;
        exp_q      <= rd_q[31:0];
      end
    end
    if (cmd_i.commit) begin
      if (live) begin
        status_q   <= ekc_pkg::ST_HIT;
        slot_out_q <= chosen_ext[ekc_pkg::SLOT_OUT_W-1:0];
        evicted_q  <= 1'b0;
      end else begin
        status_q   <= ok_q ? ekc_pkg::ST_FILLED : ekc_pkg::ST_FAILED;
        slot_out_q <= chosen_ext[ekc_pkg::SLOT_OUT_W-1:0];
        evicted_q  <= victim;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= ekc_pkg::LIFETIME_RESET;
      issue_q    <= '0;
      cmp_en_q   <= 1'b0;
      found_q    <= 1'b0;
      valid_q    <= '0;
      ptr_q      <= '0;
      forced_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        lifetime_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        issue_q  <= '0;
        cmp_en_q <= 1'b0;
        found_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        if (!issue_full) begin
          issue_q  <= issue_q + 1'b1;
          cmp_en_q <= 1'b1;
        end else begin
          cmp_en_q <= 1'b0;
        end
        if (hit_now) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit && !live) begin
        if (!found_q) begin
          ptr_q <= ptr_wrap + 1'b1;
        end
        if (victim) begin
          forced_q <= forced_q + 32'd1;
        end
        valid_q[chosen] <= ok_q;
      end
    end
  end

  assign status_o       = status_q;
  assign slot_index_o   = slot_out_q;
  assign evicted_o      = evicted_q;
  assign forced_total_o = forced_q;

endmodule

/* src/expiring_keyed_cache_round_robin_unit.sv */
// Keyed handle cache with expiry and round-robin refill. Each request word
// carries a key (host address, program number, version), the current time
// and a create_ok flag, and returns one word: status (0 live hit, 1 filled,
// 2 create failed), slot, evicted flag and the running forced-eviction count.
// The 64-entry table sits in a single-port-read memory that is scanned one
// entry per cycle until a key match or the end of the table; one request is
// in flight at a time. The lifetime register (reset 20 s) is written through
// cfg_we_i/cfg_data_i while the block is idle; this binds the user, the block
// itself does not enforce it. The table needs no clearing pass after reset.
`include "expiring_keyed_cache_round_robin_unit_macros.svh"

module expiring_keyed_cache_round_robin_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] host_address_i,
  input  logic [31:0] program_number_i,
  input  logic [31:0] program_version_i,
  input  logic [31:0] now_seconds_i,
  input  logic        create_ok_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_index_o,
  output logic        evicted_o,
  output logic [31:0] forced_total_o
);

  ekc_pkg::ekc_cmd_t cmd;
  ekc_pkg::ekc_sts_t sts;

  ekc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ekc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .host_address_i    (host_address_i),
    .program_number_i  (program_number_i),
    .program_version_i (program_version_i),
    .now_seconds_i     (now_seconds_i),
    .create_ok_i       (create_ok_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .evicted_o         (evicted_o),
    .forced_total_o    (forced_total_o)
  );

  `EKC_ASSERT_NOW(a_commit_out_free, cmd.commit, !out_valid_o || !out_stall_i)
  `EKC_ASSERT_NOW(a_load_not_busy, cmd.load, !cmd.scan && !cmd.commit)
  `EKC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `EKC_ASSERT_NOW(a_out_from_commit, $rose(out_valid_o), $past(cmd.commit))

endmodule
